// ===== rtl/core/bqlp_pkg.sv =====
`timescale 1ns / 1ps

package bqlp_pkg;

	localparam int DATA_W    = 32;
	localparam int COEF_W    = 31;
	localparam int AXIS_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 67;
	localparam int SEED_FRAC = 24;
	localparam int STEP_W    = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_B0,
		REG_COEF_A1,
		REG_COEF_A2,
		REG_RESET_SCALE
	} cfg_reg_t;

	typedef logic [STEP_W-1:0] step_t;

	// program addresses
	localparam step_t STEP_SEED_MUL = 4'd0;
	localparam step_t STEP_SEED_ACC = 4'd1;
	localparam step_t STEP_SEED_WB  = 4'd2;
	localparam step_t STEP_FB_A1    = 4'd3;
	localparam step_t STEP_FB_A2    = 4'd4;
	localparam step_t STEP_FB_SUM   = 4'd5;
	localparam step_t STEP_W_WB     = 4'd6;
	localparam step_t STEP_Y_W      = 4'd7;
	localparam step_t STEP_Y_SUM    = 4'd8;
	localparam step_t STEP_OUT      = 4'd9;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_X_SCALE,
		MUL_A1_W1,
		MUL_A2_W2,
		MUL_B0_W1,
		MUL_B0_W2,
		MUL_B0_W
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_P,
		ACC_LOAD_P2,
		ACC_LOAD_X,
		ACC_ADD_P,
		ACC_SUB_P
	} acc_op_t;

	typedef enum logic [1:0] {
		WB_NONE,
		WB_SEED,
		WB_W,
		WB_OUT
	} wb_op_t;

	typedef enum logic {
		JMP_NEXT,
		JMP_NO_SEED
	} jmp_op_t;

	typedef struct packed {
		mul_op_t mul;
		acc_op_t acc;
		wb_op_t  wb;
		jmp_op_t jmp;
		step_t   target;
	} ucode_t;

	typedef struct packed {
		logic no_seed;
	} dp_status_t;

	localparam ucode_t UCODE_NOP = '{MUL_NONE, ACC_HOLD, WB_NONE, JMP_NEXT, STEP_SEED_MUL};

	// Control store. The accumulator always consumes the product issued one step earlier.
	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t w;
		w = UCODE_NOP;
		case (pc)
			STEP_SEED_MUL: w = '{MUL_X_SCALE, ACC_HOLD,    WB_NONE, JMP_NO_SEED, STEP_FB_A1};
			STEP_SEED_ACC: w = '{MUL_NONE,    ACC_LOAD_P,  WB_NONE, JMP_NEXT, STEP_SEED_MUL};
			STEP_SEED_WB:  w = '{MUL_NONE,    ACC_HOLD,    WB_SEED, JMP_NEXT, STEP_SEED_MUL};
			STEP_FB_A1:    w = '{MUL_A1_W1,   ACC_LOAD_X,  WB_NONE, JMP_NEXT, STEP_SEED_MUL};
			STEP_FB_A2:    w = '{MUL_A2_W2,   ACC_SUB_P,   WB_NONE, JMP_NEXT, STEP_SEED_MUL};
			STEP_FB_SUM:   w = '{MUL_B0_W1,   ACC_SUB_P,   WB_NONE, JMP_NEXT, STEP_SEED_MUL};
			STEP_W_WB:     w = '{MUL_B0_W2,   ACC_LOAD_P2, WB_W,    JMP_NEXT, STEP_SEED_MUL};
			STEP_Y_W:      w = '{MUL_B0_W,    ACC_ADD_P,   WB_NONE, JMP_NEXT, STEP_SEED_MUL};
			STEP_Y_SUM:    w = '{MUL_NONE,    ACC_ADD_P,   WB_NONE, JMP_NEXT, STEP_SEED_MUL};
			STEP_OUT:      w = '{MUL_NONE,    ACC_HOLD,    WB_OUT,  JMP_NEXT, STEP_SEED_MUL};
			default:       w = UCODE_NOP;
		endcase
		return w;
	endfunction

	function automatic logic fits32(logic [ACC_W-1:0] v);
		return (&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]);
	endfunction

	function automatic logic [DATA_W-1:0] sat32(logic [ACC_W-1:0] v);
		logic [DATA_W-1:0] r;
		if (fits32(v)) begin
			r = v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/bqlp_seq.sv =====
`timescale 1ns / 1ps

module bqlp_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bqlp_pkg::step_t      start_pc,
	input  bqlp_pkg::dp_status_t status,
	input  logic                 out_free,
	output logic                 busy,
	output bqlp_pkg::ucode_t     word
);
	import bqlp_pkg::*;

	logic   busy_q;
	step_t  pc_q;
	ucode_t rom_word;
	logic   stall;

	assign rom_word = ucode_rom(pc_q);
	// hold on the output step until the result register can take the result
	assign stall = (rom_word.wb == WB_OUT) && !out_free;
	assign word  = (busy_q && !stall) ? rom_word : UCODE_NOP;
	assign busy  = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_SEED_MUL;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= start_pc;
		end else if (busy_q && !stall) begin
			if (rom_word.wb == WB_OUT) begin
				busy_q <= 1'b0;
			end else if (rom_word.jmp == JMP_NO_SEED && status.no_seed) begin
				pc_q <= rom_word.target;
			end else begin
				pc_q <= pc_q + step_t'(1);
			end
		end
	end

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= STEP_OUT))
		else $error("step counter left the program");
	a_out_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(word.wb == WB_OUT) |=> !busy_q)
		else $error("sequencer still busy after delivering a result");
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("request started while a program was running");

endmodule

// ===== rtl/core/bqlp_dp.sv =====
`timescale 1ns / 1ps

module bqlp_dp #(
	parameter int NUM_AXES       = 3,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic                                    cmd,
	input  logic        [bqlp_pkg::AXIS_W-1:0]      axis,
	input  logic signed [bqlp_pkg::DATA_W-1:0]      sample,
	input  logic                                    axis_ok,
	input  logic        [bqlp_pkg::COEF_W-1:0]      coef_b0,
	input  logic signed [bqlp_pkg::DATA_W-1:0]      coef_a1,
	input  logic signed [bqlp_pkg::DATA_W-1:0]      coef_a2,
	input  logic signed [bqlp_pkg::DATA_W-1:0]      reset_scale,
	input  bqlp_pkg::ucode_t                        word,
	output bqlp_pkg::dp_status_t                    status,
	output logic        [bqlp_pkg::AXIS_W-1:0]      axis_res,
	output logic signed [bqlp_pkg::DATA_W-1:0]      result
);
	import bqlp_pkg::*;

	localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam logic signed [ACC_W-1:0] SEED_HALF = ACC_W'(1) << (SEED_FRAC - 1);
	localparam logic signed [ACC_W-1:0] COEF_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [DATA_W-1:0] delay_one_q [NUM_AXES];
	logic signed [DATA_W-1:0] delay_two_q [NUM_AXES];

	logic signed [DATA_W-1:0] x_q, w1_q, w2_q, w_q;
	logic        [AXIS_W-1:0] axis_q;
	logic                     cmd_q, ok_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic        [IDX_W-1:0]  in_idx, res_idx;
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [ACC_W-1:0]  prod_ext, x_ext, acc_d;
	logic signed [ACC_W-1:0]  seed_sum, seed_rnd, coef_sum, coef_rnd;

	assign in_idx  = IDX_W'(axis);
	assign res_idx = IDX_W'(axis_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (word.mul)
			MUL_X_SCALE: begin mul_a = x_q; mul_b = reset_scale; end
			MUL_A1_W1:   begin mul_a = coef_a1; mul_b = w1_q; end
			MUL_A2_W2:   begin mul_a = coef_a2; mul_b = w2_q; end
			MUL_B0_W1:   begin mul_a = {1'b0, coef_b0}; mul_b = w1_q; end
			MUL_B0_W2:   begin mul_a = {1'b0, coef_b0}; mul_b = w2_q; end
			MUL_B0_W:    begin mul_a = {1'b0, coef_b0}; mul_b = w_q; end
			default:     begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_d   = mul_a * mul_b;
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign x_ext    = {{(ACC_W-DATA_W){x_q[DATA_W-1]}}, x_q} << COEF_FRAC_BITS;

	always_comb begin
		case (word.acc)
			ACC_LOAD_P:  acc_d = prod_ext;
			ACC_LOAD_P2: acc_d = prod_ext << 1;
			ACC_LOAD_X:  acc_d = x_ext;
			ACC_ADD_P:   acc_d = acc_q + prod_ext;
			ACC_SUB_P:   acc_d = acc_q - prod_ext;
			default:     acc_d = acc_q;
		endcase
	end

	// round to nearest, ties upward: add half, then floor
	assign seed_sum = acc_q + SEED_HALF;
	assign seed_rnd = seed_sum >>> SEED_FRAC;
	assign coef_sum = acc_q + COEF_HALF;
	assign coef_rnd = coef_sum >>> COEF_FRAC_BITS;

	assign status.no_seed = !cmd_q;
	assign axis_res       = axis_q;
	assign result         = ok_q ? signed'(sat32(coef_rnd)) : '0;

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		acc_q  <= acc_d;
		if (start) begin
			x_q    <= sample;
			axis_q <= axis;
			cmd_q  <= cmd;
			ok_q   <= axis_ok;
			w1_q   <= axis_ok ? delay_one_q[in_idx] : '0;
			w2_q   <= axis_ok ? delay_two_q[in_idx] : '0;
		end else if (word.wb == WB_SEED) begin
			w1_q <= sat32(seed_rnd);
			w2_q <= sat32(seed_rnd);
		end
		if (word.wb == WB_W) begin
			w_q <= fits32(coef_rnd) ? coef_rnd[DATA_W-1:0] : x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				delay_one_q[i] <= '0;
				delay_two_q[i] <= '0;
			end
		end else if (word.wb == WB_OUT && ok_q) begin
			delay_one_q[res_idx] <= w_q;
			delay_two_q[res_idx] <= w1_q;
		end
	end

endmodule

// ===== rtl/core/biquad_lowpass_three_axis.sv =====
`timescale 1ns / 1ps
// Channel   Signals                              Moves
// input     in_valid/in_ready: cmd axis sample   one sample request per axis
// output    out_valid/out_ready: axis_out        one filtered sample per request
//           filtered
// config    cfg_we cfg_index cfg_data            coefficient writes, no wait
//
// One request occupies the sequencer for the plain filter program, or for the
// longer program with the seed steps (reset command); an axis beyond NUM_AXES
// runs only the output step. The length is set by the single shared 32x32
// multiplier: five products per sample (six with a reset) issue one per step of the program.
// Reset clears the coefficient registers and both delay lines of every axis.
// A full result register holds the sequencer on its output step; the next
// request is taken as soon as that step retires.

module biquad_lowpass_three_axis #(
	parameter int NUM_AXES       = 3,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic        [bqlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [bqlp_pkg::DATA_W-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic        [bqlp_pkg::AXIS_W-1:0]    axis,
	input  logic signed [bqlp_pkg::DATA_W-1:0]    sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [bqlp_pkg::AXIS_W-1:0]    axis_out,
	output logic signed [bqlp_pkg::DATA_W-1:0]    filtered
);
	import bqlp_pkg::*;

	// coefficient registers
	logic        [COEF_W-1:0] coef_b0_q;
	logic signed [DATA_W-1:0] coef_a1_q, coef_a2_q, reset_scale_q;

	// result register
	logic                     out_valid_q;
	logic        [AXIS_W-1:0] axis_out_q;
	logic signed [DATA_W-1:0] filtered_q;

	logic                     busy, start, axis_ok, out_free, load;
	step_t                    start_pc;
	ucode_t                   word;
	dp_status_t               status;
	logic        [AXIS_W-1:0] axis_res;
	logic signed [DATA_W-1:0] result;

	// take a request only between programs
	assign in_ready = !busy;
	assign start    = in_valid && in_ready;
	assign axis_ok  = (32'(axis) < 32'(NUM_AXES));
	// dispatch: a bad axis skips straight to the output step with a zero result
	assign start_pc = axis_ok ? STEP_SEED_MUL : STEP_OUT;

	// result register frees up when empty or drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// the sequencer only issues the output step once out_free holds
	assign load     = (word.wb == WB_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q     <= '0;
			coef_a1_q     <= '0;
			coef_a2_q     <= '0;
			reset_scale_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_B0:     coef_b0_q     <= cfg_data[COEF_W-1:0];
				REG_COEF_A1:     coef_a1_q     <= cfg_data;
				REG_COEF_A2:     coef_a2_q     <= cfg_data;
				REG_RESET_SCALE: reset_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bqlp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.start_pc (start_pc),
		.status   (status),
		.out_free (out_free),
		.busy     (busy),
		.word     (word)
	);

	bqlp_dp #(
		.NUM_AXES       (NUM_AXES),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.axis        (axis),
		.sample      (sample),
		.axis_ok     (axis_ok),
		.coef_b0     (coef_b0_q),
		.coef_a1     (coef_a1_q),
		.coef_a2     (coef_a2_q),
		.reset_scale (reset_scale_q),
		.word        (word),
		.status      (status),
		.axis_res    (axis_res),
		.result      (result)
	);

	// hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			axis_out_q <= axis_res;
			filtered_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign axis_out  = axis_out_q;
	assign filtered  = filtered_q;

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("second request accepted while a program runs");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(load))
		else $error("result appeared without a finished program");

endmodule
